@@ hdl/swlt_pkg.sv @@
// ----------------------------------------------------------------------------
// swlt_pkg
// Shared types, codes and constants of the stop-and-wait link transport core.
// ----------------------------------------------------------------------------
package swlt_pkg;

  localparam int RX_QUEUE_DEPTH = 8;
  localparam int RXQ_PTR_W  = (RX_QUEUE_DEPTH > 1) ? $clog2(RX_QUEUE_DEPTH) : 1;
  localparam int RXQ_FILL_W = $clog2(RX_QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACK_TIMEOUT = 1'd0,
    CFG_MAX_TRIES   = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_RECV = 2'd1,
    CMD_TICK = 2'd2,
    CMD_POLL = 2'd3
  } cmd_t;

  localparam logic [2:0] KIND_GOTO = 3'd2;
  localparam logic [2:0] KIND_STOP = 3'd3;
  localparam logic [2:0] KIND_PAIR = 3'd4;
  localparam logic [2:0] KIND_ACK  = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  frame_kind;
    logic [7:0]  frame_seq;
    logic [31:0] frame_handle;
    logic        frame_ok;
    logic [31:0] now_ms;
    logic        radio_busy;
    logic        duty_allowed;
    logic        transmit_ok;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  engine_state;
    logic [2:0]  out_kind;
    logic [7:0]  out_seq;
    logic [31:0] out_handle;
    logic        link_up;
    logic [3:0]  queue_count;
    logic [15:0] sent_count;
    logic [15:0] failed_count;
    logic [15:0] duty_refused_count;
    logic [15:0] rx_bad_count;
    logic [15:0] rx_good_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] ack_window;
    logic [3:0]  try_limit;
  } cfg_t;

  // Engine status after the current transfer has been applied.
  typedef struct packed {
    logic        accepted;
    logic [1:0]  engine_state;
    logic        link_up;
    logic        ack_hit;
    logic [15:0] sent_count;
    logic [15:0] failed_count;
    logic [15:0] duty_refused_count;
    logic [15:0] rx_bad_count;
    logic [15:0] rx_good_count;
  } eng_status_t;

  // Receive queue status after the current transfer has been applied.
  typedef struct packed {
    logic                  popped;
    logic [2:0]            kind;
    logic [7:0]            seq;
    logic [31:0]           handle;
    logic [RXQ_FILL_W-1:0] fill;
  } rxq_status_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

@@ hdl/stop_and_wait_link_transport_core.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_link_transport_core
// Stop-and-wait transmit engine with ack window, retries and receive queue.
// ----------------------------------------------------------------------------
// Every input transfer produces exactly one result transfer. An item is
// captured in an input register, applied to the engine and receive queue
// state when the output register can take its result, and that result is
// loaded into the output register. The core sustains one item per clock
// as long as out_stall stays low. The output register decouples the two
// sides: a waiting result holds only the one item behind it in the input
// register. Configuration writes take effect at the next clock edge and
// should be issued while no item is in flight.
module stop_and_wait_link_transport_core import swlt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r, out_item_nxt;
  cfg_t        cfg_r;
  logic        advance;
  logic        take_in;
  eng_status_t eng;
  rxq_status_t rxq;
  logic [RXQ_FILL_W+3:0] fill_ext;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_window <= 16'd250;
      cfg_r.try_limit  <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACK_TIMEOUT: cfg_r.ack_window <= cfg_wdata;
        CFG_MAX_TRIES:   cfg_r.try_limit  <= cfg_wdata[3:0];
        default:         cfg_r            <= cfg_r;
      endcase
    end
  end

  swlt_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .status (eng)
  );

  swlt_rxq u_rxq (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (in_item_r),
    .ack_hit (eng.ack_hit),
    .status  (rxq)
  );

  assign fill_ext = {4'd0, rxq.fill};

  always_comb begin
    out_item_nxt.accepted           = eng.accepted | rxq.popped;
    out_item_nxt.engine_state       = eng.engine_state;
    out_item_nxt.out_kind           = rxq.kind;
    out_item_nxt.out_seq            = rxq.seq;
    out_item_nxt.out_handle         = rxq.handle;
    out_item_nxt.link_up            = eng.link_up;
    out_item_nxt.queue_count        = fill_ext[3:0];
    out_item_nxt.sent_count         = eng.sent_count;
    out_item_nxt.failed_count       = eng.failed_count;
    out_item_nxt.duty_refused_count = eng.duty_refused_count;
    out_item_nxt.rx_bad_count       = eng.rx_bad_count;
    out_item_nxt.rx_good_count      = eng.rx_good_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

@@ hdl/swlt_engine.sv @@
// ----------------------------------------------------------------------------
// swlt_engine
// Stop-and-wait transmit state, link flag and saturating statistics.
// ----------------------------------------------------------------------------
module swlt_engine import swlt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_item_t    item,
  input  cfg_t        cfg,
  output eng_status_t status
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PENDING = 2'd1,
    MODE_SENDING = 2'd2,
    MODE_AWAIT   = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  pend_seq_r, pend_seq_nxt;
  logic [3:0]  tries_r, tries_nxt;
  logic        ack_want_r, ack_want_nxt;
  logic        duty_blk_r, duty_blk_nxt;
  logic [31:0] last_send_r, last_send_nxt;
  logic        link_r, link_nxt;
  logic [15:0] sent_r, sent_nxt;
  logic [15:0] failed_r, failed_nxt;
  logic [15:0] duty_r, duty_nxt;
  logic [15:0] rxbad_r, rxbad_nxt;
  logic [15:0] rxgood_r, rxgood_nxt;
  logic        acc;
  logic        ack_hit;
  logic [31:0] elapsed;
  logic        expired;

  assign elapsed = item.now_ms - last_send_r;
  assign expired = (elapsed >= {16'd0, cfg.ack_window});

  always_comb begin
    mode_nxt      = mode_r;
    pend_seq_nxt  = pend_seq_r;
    tries_nxt     = tries_r;
    ack_want_nxt  = ack_want_r;
    duty_blk_nxt  = duty_blk_r;
    last_send_nxt = last_send_r;
    link_nxt      = link_r;
    sent_nxt      = sent_r;
    failed_nxt    = failed_r;
    duty_nxt      = duty_r;
    rxbad_nxt     = rxbad_r;
    rxgood_nxt    = rxgood_r;
    acc           = 1'b0;
    ack_hit       = 1'b0;
    if (fire) begin
      case (cmd_t'(item.command))
        CMD_SEND: begin
          if (mode_r == MODE_IDLE && item.frame_ok) begin
            pend_seq_nxt = item.frame_seq;
            tries_nxt    = 4'd0;
            mode_nxt     = MODE_PENDING;
            ack_want_nxt = (item.frame_kind == KIND_GOTO) ||
                           (item.frame_kind == KIND_STOP) ||
                           (item.frame_kind == KIND_PAIR);
            acc          = 1'b1;
          end
        end
        CMD_RECV: begin
          if (!item.frame_ok) begin
            rxbad_nxt = sat_inc(rxbad_r);
          end else begin
            rxgood_nxt = sat_inc(rxgood_r);
            link_nxt   = 1'b1;
            if (item.frame_kind == KIND_ACK && mode_r == MODE_AWAIT &&
                item.frame_seq == pend_seq_r) begin
              ack_hit  = 1'b1;
              mode_nxt = MODE_IDLE;
            end
          end
        end
        CMD_TICK: begin
          case (mode_r)
            MODE_PENDING: begin
              if (!item.radio_busy) begin
                if (!item.duty_allowed) begin
                  // A run of duty refusals is counted on its first tick only.
                  if (!duty_blk_r) begin
                    duty_nxt     = sat_inc(duty_r);
                    duty_blk_nxt = 1'b1;
                  end
                end else begin
                  duty_blk_nxt = 1'b0;
                  if (!item.transmit_ok) begin
                    failed_nxt = sat_inc(failed_r);
                  end else begin
                    sent_nxt      = sat_inc(sent_r);
                    tries_nxt     = (tries_r == 4'd15) ? tries_r : tries_r + 4'd1;
                    last_send_nxt = item.now_ms;
                    mode_nxt      = MODE_SENDING;
                    acc           = 1'b1;
                  end
                end
              end
            end
            MODE_SENDING: begin
              if (!item.radio_busy) begin
                mode_nxt = ack_want_r ? MODE_AWAIT : MODE_IDLE;
              end
            end
            MODE_AWAIT: begin
              if (expired) begin
                if (tries_r >= cfg.try_limit) begin
                  failed_nxt = sat_inc(failed_r);
                  link_nxt   = 1'b0;
                  mode_nxt   = MODE_IDLE;
                end else begin
                  mode_nxt = MODE_PENDING;
                end
              end
            end
            default: begin
              mode_nxt = mode_r;
            end
          endcase
        end
        default: begin
          acc = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pend_seq_r  <= 8'd0;
      tries_r     <= 4'd0;
      ack_want_r  <= 1'b0;
      duty_blk_r  <= 1'b0;
      last_send_r <= 32'd0;
      link_r      <= 1'b0;
      sent_r      <= 16'd0;
      failed_r    <= 16'd0;
      duty_r      <= 16'd0;
      rxbad_r     <= 16'd0;
      rxgood_r    <= 16'd0;
    end else begin
      mode_r      <= mode_nxt;
      pend_seq_r  <= pend_seq_nxt;
      tries_r     <= tries_nxt;
      ack_want_r  <= ack_want_nxt;
      duty_blk_r  <= duty_blk_nxt;
      last_send_r <= last_send_nxt;
      link_r      <= link_nxt;
      sent_r      <= sent_nxt;
      failed_r    <= failed_nxt;
      duty_r      <= duty_nxt;
      rxbad_r     <= rxbad_nxt;
      rxgood_r    <= rxgood_nxt;
    end
  end

  assign status.accepted           = acc;
  assign status.engine_state       = mode_nxt;
  assign status.link_up            = link_nxt;
  assign status.ack_hit            = ack_hit;
  assign status.sent_count         = sent_nxt;
  assign status.failed_count       = failed_nxt;
  assign status.duty_refused_count = duty_nxt;
  assign status.rx_bad_count       = rxbad_nxt;
  assign status.rx_good_count      = rxgood_nxt;

endmodule

@@ hdl/swlt_rxq.sv @@
// ----------------------------------------------------------------------------
// swlt_rxq
// Receive frame queue: circular buffer with head and tail pointers.
// ----------------------------------------------------------------------------
module swlt_rxq import swlt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_item_t    item,
  input  logic        ack_hit,
  output rxq_status_t status
);

  logic [42:0]           store_r [RX_QUEUE_DEPTH];
  logic [RXQ_PTR_W-1:0]  head_r, head_nxt;
  logic [RXQ_PTR_W-1:0]  tail_r, tail_nxt;
  logic [RXQ_FILL_W-1:0] fill_r, fill_nxt;
  logic                  push;
  logic                  pop;
  logic [42:0]           head_word;

  localparam logic [RXQ_PTR_W-1:0]  LAST_PTR = RXQ_PTR_W'(RX_QUEUE_DEPTH - 1);
  localparam logic [RXQ_FILL_W-1:0] FULL     = RXQ_FILL_W'(RX_QUEUE_DEPTH);

  // A good frame that did not close the ack window enters the queue when
  // there is room; otherwise it is dropped.
  assign push = fire && (cmd_t'(item.command) == CMD_RECV) && item.frame_ok &&
                !ack_hit && (fill_r != FULL);
  assign pop  = fire && (cmd_t'(item.command) == CMD_POLL) && (fill_r != '0);

  assign head_word = store_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push) begin
      tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end else if (pop) begin
      head_nxt = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[tail_r] <= {item.frame_kind, item.frame_seq, item.frame_handle};
    end
  end

  assign status.popped = pop;
  assign status.kind   = pop ? head_word[42:40] : 3'd0;
  assign status.seq    = pop ? head_word[39:32] : 8'd0;
  assign status.handle = pop ? head_word[31:0]  : 32'd0;
  assign status.fill   = fill_nxt;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stop-and-wait link transport core. A directed
// opening walks the engine through refusals, duty runs, radio refusals,
// wrapped ack windows, retries and ack clearing. Random send exchanges,
// receive floods and stray items follow under several register settings.
// Every result transfer is checked field by field against an in-bench
// prediction of the engine and receive queue.
// ----------------------------------------------------------------------------
module tb_top;
  import swlt_pkg::*;

  typedef enum logic [1:0] {
    ENG_IDLE    = 2'd0,
    ENG_PENDING = 2'd1,
    ENG_SENDING = 2'd2,
    ENG_AWAIT   = 2'd3
  } eng_mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  seq;
    logic [31:0] handle;
  } rx_frame_t;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned REPORT_CAP = 200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stop_and_wait_link_transport_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted engine, queue and counter state.
  logic [15:0] ack_to = 16'd250;
  logic [3:0]  tries_lim = 4'd3;
  eng_mode_t   eng = ENG_IDLE;
  logic [7:0]  pend_seq = '0;
  logic [3:0]  tries = '0;
  logic        wants_ack = 1'b0;
  logic        duty_held = 1'b0;
  logic [31:0] last_tx_ms = '0;
  logic        link_ok = 1'b0;
  rx_frame_t   rxq [RX_QUEUE_DEPTH];
  int unsigned rxq_fill = 0;
  logic [15:0] sent_cnt = '0;
  logic [15:0] fail_cnt = '0;
  logic [15:0] duty_cnt = '0;
  logic [15:0] rx_bad_cnt = '0;
  logic [15:0] rx_good_cnt = '0;

  in_item_t    pending_items [$];
  out_item_t   expected_status [$];
  logic [31:0] clock_ms = '0;
  int unsigned items_made = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  function automatic logic [15:0] count_up(input logic [15:0] v);
    return v + {15'd0, ~&v};
  endfunction

  function automatic out_item_t predict_link_result(input in_item_t it);
    out_item_t   r;
    logic [31:0] waited;
    int unsigned i;
    r = '0;
    waited = it.now_ms - last_tx_ms;
    case (it.command)
      CMD_SEND: begin
        if (eng == ENG_IDLE && it.frame_ok) begin
          pend_seq = it.frame_seq;
          tries = '0;
          eng = ENG_PENDING;
          wants_ack = (it.frame_kind == KIND_GOTO) || (it.frame_kind == KIND_STOP) ||
                      (it.frame_kind == KIND_PAIR);
          r.accepted = 1'b1;
        end
      end
      CMD_RECV: begin
        if (!it.frame_ok) begin
          rx_bad_cnt = count_up(rx_bad_cnt);
        end else begin
          rx_good_cnt = count_up(rx_good_cnt);
          link_ok = 1'b1;
          if (it.frame_kind == KIND_ACK && eng == ENG_AWAIT && it.frame_seq == pend_seq) begin
            eng = ENG_IDLE;
          end else if (rxq_fill < RX_QUEUE_DEPTH) begin
            rxq[rxq_fill] = '{kind: it.frame_kind, seq: it.frame_seq, handle: it.frame_handle};
            rxq_fill++;
          end
        end
      end
      CMD_TICK: begin
        case (eng)
          ENG_PENDING: begin
            if (!it.radio_busy) begin
              if (!it.duty_allowed) begin
                // A run of duty refusals is counted on its first tick only.
                if (!duty_held) begin
                  duty_cnt = count_up(duty_cnt);
                  duty_held = 1'b1;
                end
              end else begin
                duty_held = 1'b0;
                if (!it.transmit_ok) begin
                  fail_cnt = count_up(fail_cnt);
                end else begin
                  sent_cnt = count_up(sent_cnt);
                  if (tries != 4'd15) tries++;
                  last_tx_ms = it.now_ms;
                  eng = ENG_SENDING;
                  r.accepted = 1'b1;
                end
              end
            end
          end
          ENG_SENDING: begin
            if (!it.radio_busy) eng = wants_ack ? ENG_AWAIT : ENG_IDLE;
          end
          ENG_AWAIT: begin
            if (waited >= {16'd0, ack_to}) begin
              if (tries >= tries_lim) begin
                fail_cnt = count_up(fail_cnt);
                link_ok = 1'b0;
                eng = ENG_IDLE;
              end else begin
                eng = ENG_PENDING;
              end
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (rxq_fill != 0) begin
          r.out_kind = rxq[0].kind;
          r.out_seq = rxq[0].seq;
          r.out_handle = rxq[0].handle;
          for (i = 1; i < rxq_fill; i++) rxq[i - 1] = rxq[i];
          rxq_fill--;
          r.accepted = 1'b1;
        end
      end
    endcase
    r.engine_state = eng;
    r.link_up = link_ok;
    r.queue_count = rxq_fill[3:0];
    r.sent_count = sent_cnt;
    r.failed_count = fail_cnt;
    r.duty_refused_count = duty_cnt;
    r.rx_bad_count = rx_bad_cnt;
    r.rx_good_count = rx_good_cnt;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  bit          in_fire;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) expected_status.push_back(predict_link_result(in_data));
      if (!in_valid || in_fire) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern in randomly chosen modes of random length, plus
  // one long hold-off that backs the core up into its input.
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && results_seen >= 200) begin
      long_hold_done = 1'b1;
      hold_left = 80;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  out_item_t want_item;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, expected none, actual %h",
                 $time, out_data);
      end else begin
        want_item = expected_status.pop_front();
        check_field("accepted", 32'(want_item.accepted), 32'(out_data.accepted));
        check_field("engine_state", 32'(want_item.engine_state),
                    32'(out_data.engine_state));
        check_field("out_kind", 32'(want_item.out_kind), 32'(out_data.out_kind));
        check_field("out_seq", 32'(want_item.out_seq), 32'(out_data.out_seq));
        check_field("out_handle", want_item.out_handle, out_data.out_handle);
        check_field("link_up", 32'(want_item.link_up), 32'(out_data.link_up));
        check_field("queue_count", 32'(want_item.queue_count), 32'(out_data.queue_count));
        check_field("sent_count", 32'(want_item.sent_count), 32'(out_data.sent_count));
        check_field("failed_count", 32'(want_item.failed_count),
                    32'(out_data.failed_count));
        check_field("duty_refused_count", 32'(want_item.duty_refused_count),
                    32'(out_data.duty_refused_count));
        check_field("rx_bad_count", 32'(want_item.rx_bad_count),
                    32'(out_data.rx_bad_count));
        check_field("rx_good_count", 32'(want_item.rx_good_count),
                    32'(out_data.rx_good_count));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                   $time, IDLE_LIMIT, expected_status.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic add_item(input cmd_t c, input logic [2:0] kind, input logic [7:0] seq,
                          input logic [31:0] handle, input bit ok, input bit busy,
                          input bit duty, input bit tx);
    in_item_t it;
    it.command = c;
    it.frame_kind = kind;
    it.frame_seq = seq;
    it.frame_handle = handle;
    it.frame_ok = ok;
    it.now_ms = clock_ms;
    it.radio_busy = busy;
    it.duty_allowed = duty;
    it.transmit_ok = tx;
    pending_items.push_back(it);
    items_made++;
  endtask

  task automatic step_clock();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) clock_ms += $urandom_range(0, 40);
    else if (pick < 16) clock_ms += $urandom_range(0, 2 * ack_to + 2);
    else if (pick == 16) clock_ms += ack_to;
    else if (pick == 17) clock_ms += ack_to - 1;
    else clock_ms += $urandom;
  endtask

  task automatic queue_tick(input bit busy, input bit duty, input bit tx);
    add_item(CMD_TICK, 3'($urandom), 8'($urandom), $urandom, 1'($urandom), busy, duty, tx);
  endtask

  // Send, a run of ticks, usually an ack and sometimes expired ack windows.
  task automatic queue_send_exchange();
    logic [7:0]  s;
    logic [2:0]  k;
    int unsigned n;
    s = 8'($urandom);
    k = ($urandom_range(0, 9) < 7) ? 3'(KIND_GOTO + $urandom_range(0, 2)) :
                                     3'($urandom_range(0, 7));
    add_item(CMD_SEND, k, s, $urandom, $urandom_range(0, 9) != 0, 1'($urandom),
             1'($urandom), 1'($urandom));
    n = $urandom_range(1, 8);
    repeat (n) begin
      step_clock();
      queue_tick($urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0,
                 $urandom_range(0, 6) != 0);
      if ($urandom_range(0, 5) == 0)
        add_item(CMD_RECV, KIND_ACK, s, $urandom, 1'b1, 1'($urandom), 1'($urandom),
                 1'($urandom));
    end
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 4)) begin
        clock_ms += ack_to + $urandom_range(0, 5);
        queue_tick(1'b0, 1'b1, 1'b1);
        queue_tick(1'b0, 1'($urandom), 1'($urandom));
      end
    end
    if ($urandom_range(0, 3) != 0)
      add_item(CMD_RECV, KIND_ACK, ($urandom_range(0, 3) != 0) ? s : 8'($urandom), $urandom,
               $urandom_range(0, 9) != 0, 1'($urandom), 1'($urandom), 1'($urandom));
    if ($urandom_range(0, 1) == 0)
      add_item(CMD_POLL, 3'($urandom), 8'($urandom), $urandom, 1'($urandom), 1'($urandom),
               1'($urandom), 1'($urandom));
  endtask

  // Inbound frames, now and then enough to overrun the queue, then polls.
  task automatic queue_inbound_frames();
    int unsigned n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 3);
    repeat (n)
      add_item(CMD_RECV, 3'($urandom_range(0, 7)), 8'($urandom), $urandom,
               $urandom_range(0, 6) != 0, 1'($urandom), 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 4))
      add_item(CMD_POLL, 3'($urandom), 8'($urandom), $urandom, 1'($urandom), 1'($urandom),
               1'($urandom), 1'($urandom));
  endtask

  task automatic queue_random_items(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    start = items_made;
    while (items_made - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        queue_send_exchange();
      end else if (pick < 8) begin
        queue_inbound_frames();
      end else begin
        step_clock();
        add_item(cmd_t'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), $urandom,
                 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic queue_directed_items();
    add_item(CMD_POLL, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
    add_item(CMD_RECV, 3'd1, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_item(CMD_SEND, KIND_GOTO, 8'hA5, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1);
    add_item(CMD_SEND, KIND_GOTO, 8'hA5, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1);
    add_item(CMD_SEND, 3'd0, 8'h11, 32'h1234_5678, 1'b1, 1'b0, 1'b1, 1'b1);
    clock_ms = 32'hFFFF_FF00;
    queue_tick(1'b1, 1'b1, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b1, 1'b0);
    // The ack window below straddles the wrap of the millisecond clock.
    clock_ms = 32'hFFFF_FFC0;
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b0);
    add_item(CMD_RECV, KIND_ACK, 8'h5A, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0);
    clock_ms += 249;
    queue_tick(1'b0, 1'b1, 1'b1);
    clock_ms += 1;
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b0, 1'b1, 1'b1);
    add_item(CMD_RECV, KIND_ACK, 8'hA5, 32'hDEAD_0001, 1'b1, 1'b1, 1'b1, 1'b1);
    add_item(CMD_POLL, 3'd0, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_item(CMD_SEND, 3'd7, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b0, 1'b1, 1'b1);
    add_item(CMD_RECV, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
    add_item(CMD_POLL, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    if (idx == CFG_ACK_TIMEOUT) ack_to = value;
    else tries_lim = value[3:0];
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every item returns one result, so an empty expectation store with no
  // item offered means the core holds nothing.
  task automatic wait_for_drain();
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    queue_directed_items();
    queue_random_items(50);
    wait_for_drain();
    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
          write_reg(CFG_MAX_TRIES, 16'd15);
        end
        2: begin
          write_reg(CFG_ACK_TIMEOUT, 16'd1);
          write_reg(CFG_MAX_TRIES, 16'd1);
        end
        3: begin
          // A zero tries limit fails the frame at its first expired window.
          write_reg(CFG_ACK_TIMEOUT, 16'd0);
          write_reg(CFG_MAX_TRIES, 16'd0);
        end
        4: begin
          write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(2, 600)));
          write_reg(CFG_MAX_TRIES, 16'($urandom_range(2, 14)));
        end
        default: begin
          write_reg(CFG_ACK_TIMEOUT, 16'd250);
          write_reg(CFG_MAX_TRIES, 16'd3);
        end
      endcase
      queue_random_items(100);
      wait_for_drain();
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived", $time, mismatches,
               expected_status.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/swlt_pkg.sv
hdl/swlt_engine.sv
hdl/swlt_rxq.sv
hdl/stop_and_wait_link_transport_core.sv
tb/sv/tb_top.sv
